### sv/foreground_boundary_distances_assert.svh
// Assertion macros for the foreground boundary distances block.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef FOREGROUND_BOUNDARY_DISTANCES_ASSERT_SVH
`define FOREGROUND_BOUNDARY_DISTANCES_ASSERT_SVH
`ifndef SYNTHESIS
`define FBD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBD_ASSERT(label, ante, cons)
`define FBD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/fbd_pkg.sv
// Package for the foreground boundary distances block: sizes, codes and types.
// No dependencies.
package fbd_pkg;
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int COORD_W    = 9;
  localparam int SWEEP_LEN  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SWEEP_W    = $clog2(SWEEP_LEN);
  localparam int ROI_W      = 10;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 10;
  localparam int PIX_W      = 16;
  localparam int DIAG_W     = 10;
  localparam int RAD_W      = 20;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_CW    = 4;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_ROI_X = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROI_Y = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ROI_W = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_ROI_H = 2'd3;

  typedef struct packed {
    logic                seen;
    logic [COORD_W-1:0]  first;
    logic [COORD_W-1:0]  last;
  } bnd_t;

  typedef struct packed {
    logic               latch;
    logic               rd;
    logic               wr;
    logic               sweep;
    logic [SWEEP_W-1:0] sweep_addr;
    logic               calc;
    logic               sum;
    logic               root_step;
    logic               out_load;
  } fbd_cmd_t;
endpackage

### sv/fbd_if.sv
// Handshake channel interfaces for the foreground boundary distances block.
// Depends on fbd_pkg.
interface fbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [fbd_pkg::COORD_W-1:0]   col;
  logic [fbd_pkg::COORD_W-1:0]   row;
  logic signed [fbd_pkg::PIX_W-1:0] pixel_value;
  modport source (output valid, cmd, col, row, pixel_value, input ready);
  modport sink (input valid, cmd, col, row, pixel_value, output ready);
endinterface

interface fbd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_foreground;
  logic [fbd_pkg::COORD_W-1:0]   dist_top;
  logic [fbd_pkg::COORD_W-1:0]   dist_bottom;
  logic [fbd_pkg::COORD_W-1:0]   dist_left;
  logic [fbd_pkg::COORD_W-1:0]   dist_right;
  logic [fbd_pkg::DIAG_W-1:0]    diag_top_left;
  logic [fbd_pkg::DIAG_W-1:0]    diag_top_right;
  logic [fbd_pkg::DIAG_W-1:0]    diag_bottom_left;
  logic [fbd_pkg::DIAG_W-1:0]    diag_bottom_right;
  modport source (output valid, is_foreground, dist_top, dist_bottom, dist_left, dist_right,
                  diag_top_left, diag_top_right, diag_bottom_left, diag_bottom_right,
                  input ready);
  modport sink (input valid, is_foreground, dist_top, dist_bottom, dist_left, dist_right,
                diag_top_left, diag_top_right, diag_bottom_left, diag_bottom_right,
                output ready);
endinterface

interface fbd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fbd_pkg::CFG_IW-1:0]   index;
  logic [fbd_pkg::CFG_DW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/fbd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### sv/fbd_ctrl.sv
// Controller state machine: clearing sweep, load and query sequencing.
// Depends on fbd_pkg and foreground_boundary_distances_assert.svh.
`include "foreground_boundary_distances_assert.svh"
module fbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fbd_pkg::fbd_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_RD, S_WR, S_DIST, S_SUM, S_ROOT, S_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [fbd_pkg::SWEEP_W-1:0]   sweep_q, sweep_d;
  logic [fbd_pkg::ROOT_CW-1:0]   step_q, step_d;
  logic                          query_q, query_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept;
  logic                          out_free;
  logic                          rmw_start;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign rmw_start   = accept && (in_cmd_i == fbd_pkg::CMD_LOAD || in_cmd_i == fbd_pkg::CMD_QUERY);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    step_d      = step_q;
    query_d     = query_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.sweep_addr = sweep_q;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        sweep_d     = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          unique case (in_cmd_i) inside
            fbd_pkg::CMD_CLEAR: begin
              sweep_d = '0;
              state_d = S_SWEEP;
            end
            fbd_pkg::CMD_LOAD, fbd_pkg::CMD_QUERY: begin
              query_d = (in_cmd_i == fbd_pkg::CMD_QUERY);
              state_d = S_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = query_q ? S_DIST : S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_IDLE;
      end
      S_DIST: begin
        cmd_o.calc = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        step_d    = '0;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == fbd_pkg::ROOT_CW'(fbd_pkg::ROOT_STEPS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      step_q      <= '0;
      query_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      step_q      <= step_d;
      query_q     <= query_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FBD_ASSERT(a_no_accept_in_sweep, cmd_o.sweep, !in_ready_o)
  `FBD_ASSERT(a_no_result_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i)
  `FBD_ASSERT_NEXT(a_result_shown, cmd_o.out_load, out_valid_o)
  `FBD_ASSERT_NEXT(a_read_follows_accept, rmw_start, cmd_o.rd)
endmodule

### sv/fbd_dp.sv
// Datapath: region registers, pixel map and boundary memories, distances
// and four bit-serial square root lanes. Depends on fbd_pkg, fbd_if, fbd_ram.
module fbd_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  fbd_in_if.sink            in_i,
  fbd_cfg_if.sink           cfg_i,
  fbd_out_if.source         out_o,
  input  fbd_pkg::fbd_cmd_t cmd_i
);
  localparam int CW = fbd_pkg::COORD_W;
  localparam int RW = fbd_pkg::RAD_W;
  localparam int SW = 2 * CW;

  logic [CW-1:0]               roi_x_q, roi_y_q;
  logic [fbd_pkg::ROI_W-1:0]   roi_w_q, roi_h_q;
  logic [CW-1:0]               col_q, row_q;
  logic                        fg_q;
  logic [fbd_pkg::MAX_WIDTH-1:0] map_rd, map_wd;
  fbd_pkg::bnd_t               colb_rd, rowb_rd, colb_wd, rowb_wd;
  logic                        in_reg;
  logic [CW+1:0]               w_eff, h_eff;
  logic                        map_we, colb_we, rowb_we;
  logic [CW-1:0]               map_wa, colb_wa;
  logic [CW-1:0]               d_t, d_b, d_l, d_g;
  logic                        is_fg_c;
  logic [CW-1:0]               t_q, b_q, l_q, g_q;
  logic                        is_fg_q;
  logic [SW-1:0]               sq_t_q, sq_b_q, sq_l_q, sq_g_q;
  logic [RW-1:0]               v_q [4];
  logic [RW-1:0]               res_q [4];
  logic [RW-1:0]               bit_q;
  logic [SW-1:0]               sq_a [4];
  logic [SW-1:0]               sq_b [4];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_x_q <= '0;
      roi_y_q <= '0;
      roi_w_q <= fbd_pkg::ROI_W'(fbd_pkg::MAX_WIDTH);
      roi_h_q <= fbd_pkg::ROI_W'(fbd_pkg::MAX_HEIGHT);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        fbd_pkg::CFG_ROI_X: roi_x_q <= cfg_i.data[CW-1:0];
        fbd_pkg::CFG_ROI_Y: roi_y_q <= cfg_i.data[CW-1:0];
        fbd_pkg::CFG_ROI_W: roi_w_q <= cfg_i.data;
        fbd_pkg::CFG_ROI_H: roi_h_q <= cfg_i.data;
        default: roi_x_q <= roi_x_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      col_q <= in_i.col;
      row_q <= in_i.row;
      fg_q  <= (in_i.pixel_value > 0);
    end
  end

  assign w_eff  = (roi_w_q == '0) ? (CW+2)'(fbd_pkg::MAX_WIDTH) : (CW+2)'(roi_w_q);
  assign h_eff  = (roi_h_q == '0) ? (CW+2)'(fbd_pkg::MAX_HEIGHT) : (CW+2)'(roi_h_q);
  assign in_reg = (col_q >= roi_x_q) && ((CW+2)'(col_q) < (CW+2)'(roi_x_q) + w_eff)
               && (row_q >= roi_y_q) && ((CW+2)'(row_q) < (CW+2)'(roi_y_q) + h_eff);

  always_comb begin
    map_wd         = map_rd;
    map_wd[col_q]  = fg_q;
    colb_wd.seen   = 1'b1;
    colb_wd.first  = (!colb_rd.seen || row_q < colb_rd.first) ? row_q : colb_rd.first;
    colb_wd.last   = (!colb_rd.seen || row_q > colb_rd.last) ? row_q : colb_rd.last;
    rowb_wd.seen   = 1'b1;
    rowb_wd.first  = (!rowb_rd.seen || col_q < rowb_rd.first) ? col_q : rowb_rd.first;
    rowb_wd.last   = (!rowb_rd.seen || col_q > rowb_rd.last) ? col_q : rowb_rd.last;
    if (cmd_i.sweep) begin
      map_wd  = '0;
      colb_wd = '0;
      rowb_wd = '0;
    end
  end

  assign map_we  = cmd_i.sweep || cmd_i.wr;
  assign colb_we = cmd_i.sweep || (cmd_i.wr && fg_q && in_reg);
  assign rowb_we = colb_we;
  assign map_wa  = cmd_i.sweep ? cmd_i.sweep_addr[CW-1:0] : row_q;
  assign colb_wa = cmd_i.sweep ? cmd_i.sweep_addr[CW-1:0] : col_q;

  fbd_ram #(.WIDTH(fbd_pkg::MAX_WIDTH), .DEPTH(fbd_pkg::MAX_HEIGHT)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_wa), .wdata_i(map_wd),
    .re_i(cmd_i.rd), .raddr_i(row_q), .rdata_o(map_rd)
  );
  fbd_ram #(.WIDTH($bits(fbd_pkg::bnd_t)), .DEPTH(fbd_pkg::MAX_WIDTH)) u_colb (
    .clk_i, .we_i(colb_we), .waddr_i(colb_wa), .wdata_i(colb_wd),
    .re_i(cmd_i.rd), .raddr_i(col_q), .rdata_o(colb_rd)
  );
  fbd_ram #(.WIDTH($bits(fbd_pkg::bnd_t)), .DEPTH(fbd_pkg::MAX_HEIGHT)) u_rowb (
    .clk_i, .we_i(rowb_we), .waddr_i(map_wa), .wdata_i(rowb_wd),
    .re_i(cmd_i.rd), .raddr_i(row_q), .rdata_o(rowb_rd)
  );

  assign is_fg_c = in_reg && map_rd[col_q];
  assign d_t = (is_fg_c && colb_rd.seen && row_q >= colb_rd.first) ? row_q - colb_rd.first : '0;
  assign d_b = (is_fg_c && colb_rd.seen && colb_rd.last >= row_q) ? colb_rd.last - row_q : '0;
  assign d_l = (is_fg_c && rowb_rd.seen && col_q >= rowb_rd.first) ? col_q - rowb_rd.first : '0;
  assign d_g = (is_fg_c && rowb_rd.seen && rowb_rd.last >= col_q) ? rowb_rd.last - col_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      is_fg_q <= is_fg_c;
      t_q     <= d_t;
      b_q     <= d_b;
      l_q     <= d_l;
      g_q     <= d_g;
      sq_t_q  <= SW'(d_t) * SW'(d_t);
      sq_b_q  <= SW'(d_b) * SW'(d_b);
      sq_l_q  <= SW'(d_l) * SW'(d_l);
      sq_g_q  <= SW'(d_g) * SW'(d_g);
    end
  end

  assign sq_a[0] = sq_t_q;
  assign sq_b[0] = sq_l_q;
  assign sq_a[1] = sq_t_q;
  assign sq_b[1] = sq_g_q;
  assign sq_a[2] = sq_b_q;
  assign sq_b[2] = sq_l_q;
  assign sq_a[3] = sq_b_q;
  assign sq_b[3] = sq_g_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      bit_q <= RW'(1) << (RW - 2);
      for (int i = 0; i < 4; i++) begin
        v_q[i]   <= RW'(sq_a[i]) + RW'(sq_b[i]);
        res_q[i] <= '0;
      end
    end else if (cmd_i.root_step) begin
      bit_q <= bit_q >> 2;
      for (int i = 0; i < 4; i++) begin
        if (v_q[i] >= res_q[i] + bit_q) begin
          v_q[i]   <= v_q[i] - (res_q[i] + bit_q);
          res_q[i] <= (res_q[i] >> 1) + bit_q;
        end else begin
          res_q[i] <= res_q[i] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.is_foreground     <= is_fg_q;
      out_o.dist_top          <= t_q;
      out_o.dist_bottom       <= b_q;
      out_o.dist_left         <= l_q;
      out_o.dist_right        <= g_q;
      out_o.diag_top_left     <= res_q[0][fbd_pkg::DIAG_W-1:0];
      out_o.diag_top_right    <= res_q[1][fbd_pkg::DIAG_W-1:0];
      out_o.diag_bottom_left  <= res_q[2][fbd_pkg::DIAG_W-1:0];
      out_o.diag_bottom_right <= res_q[3][fbd_pkg::DIAG_W-1:0];
    end
  end
endmodule

### sv/foreground_boundary_distances.sv
// Foreground boundary distances: top level joining controller and datapath.
// Depends on fbd_pkg, fbd_if, fbd_ctrl, fbd_dp.
// Load: read, modify and write of map row and boundaries; one item at a time.
// Query: distances, then the ten-step square root lanes; the next item is taken only
// once the result is handed to the output register. Clear: one memory row a cycle.
// Reset starts a clearing pass; no item is taken until it ends.
module foreground_boundary_distances (
  input  logic     clk_i,
  input  logic     rst_ni,
  fbd_in_if.sink   in_i,
  fbd_cfg_if.sink  cfg_i,
  fbd_out_if.source out_o
);
  fbd_pkg::fbd_cmd_t cmd;
  logic              in_ready;

  fbd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_cmd_i(in_i.cmd), .in_ready_o(in_ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .cmd_o(cmd)
  );

  fbd_dp u_dp (
    .clk_i, .rst_ni, .in_i, .cfg_i, .out_o, .cmd_i(cmd)
  );

  assign in_i.ready = in_ready;
endmodule

### sim/fbd_tb_if.sv
// Testbench package: the expected result record used by the predictor.
// No dependencies.
package fbd_tb_pkg;
  typedef struct packed {
    logic       fg;
    logic [8:0] top;
    logic [8:0] bottom;
    logic [8:0] left;
    logic [8:0] right;
    logic [9:0] tl;
    logic [9:0] tr;
    logic [9:0] bl;
    logic [9:0] br;
  } dist_res_t;
endpackage

### sim/testbench.sv
// Testbench for foreground_boundary_distances: drives clear, load and query items and
// region settings, predicts each query result from its own copy of the slice state.
// Depends on fbd_pkg, fbd_if, fbd_tb_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbd_pkg::*;
  import fbd_tb_pkg::*;

  localparam int WATCHDOG = 200000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fbd_in_if  in_ch();
  fbd_cfg_if cfg_ch();
  fbd_out_if out_ch();

  foreground_boundary_distances u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .cfg_i (cfg_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [MAX_WIDTH-1:0] fg_map [MAX_HEIGHT];
  logic [8:0] col_lo [MAX_WIDTH];
  logic [8:0] col_hi [MAX_WIDTH];
  logic       col_ok [MAX_WIDTH];
  logic [8:0] row_lo [MAX_HEIGHT];
  logic [8:0] row_hi [MAX_HEIGHT];
  logic       row_ok [MAX_HEIGHT];
  logic [8:0] roi_x, roi_y;
  logic [9:0] roi_w, roi_h;

  dist_res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int unsigned int_root(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic bit inside_roi(int unsigned c, int unsigned r);
    int unsigned w, h;
    w = (roi_w == 0) ? MAX_WIDTH : roi_w;
    h = (roi_h == 0) ? MAX_HEIGHT : roi_h;
    return c >= roi_x && c < roi_x + w && r >= roi_y && r < roi_y + h;
  endfunction

  function automatic int unsigned span(bit ok, int unsigned a, int unsigned b);
    if (!ok || a < b) return 0;
    return (a - b) & 9'h1ff;
  endfunction

  task automatic wipe_slice();
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      fg_map[i] = '0;
      row_ok[i] = 1'b0;
    end
    for (int i = 0; i < MAX_WIDTH; i++) col_ok[i] = 1'b0;
  endtask

  task automatic predict(logic [1:0] cmd, logic [8:0] c, logic [8:0] r, logic signed [15:0] pv);
    dist_res_t res;
    int unsigned t, b, l, g;
    bit fg;
    res = '0;
    case (cmd)
      CMD_CLEAR: begin
        wipe_slice();
      end
      CMD_LOAD: begin
        fg = pv > 0;
        fg_map[r][c] = fg;
        if (fg && inside_roi(c, r)) begin
          if (!col_ok[c]) begin
            col_ok[c] = 1'b1; col_lo[c] = r; col_hi[c] = r;
          end else begin
            if (r < col_lo[c]) col_lo[c] = r;
            if (r > col_hi[c]) col_hi[c] = r;
          end
          if (!row_ok[r]) begin
            row_ok[r] = 1'b1; row_lo[r] = c; row_hi[r] = c;
          end else begin
            if (c < row_lo[r]) row_lo[r] = c;
            if (c > row_hi[r]) row_hi[r] = c;
          end
        end
      end
      CMD_QUERY: begin
        if (inside_roi(c, r) && fg_map[r][c]) begin
          t = span(col_ok[c], r, col_lo[c]);
          b = span(col_ok[c], col_hi[c], r);
          l = span(row_ok[r], c, row_lo[r]);
          g = span(row_ok[r], row_hi[r], c);
          res.fg = 1'b1;
          res.top = 9'(t); res.bottom = 9'(b); res.left = 9'(l); res.right = 9'(g);
          res.tl = 10'(int_root(t * t + l * l));
          res.tr = 10'(int_root(t * t + g * g));
          res.bl = 10'(int_root(b * b + l * l));
          res.br = 10'(int_root(b * b + g * g));
        end
        expected_q.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(logic [1:0] cmd, logic [8:0] c, logic [8:0] r,
                           logic signed [15:0] pv);
    int unsigned gap;
    gap = gap_len();
    repeat (gap + 1) @(posedge clk_i);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.col         <= c;
    in_ch.row         <= r;
    in_ch.pixel_value <= pv;
    do @(posedge clk_i); while (!in_ch.ready);
    predict(cmd, c, r, pv);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ROI_X: roi_x = val[8:0];
      CFG_ROI_Y: roi_y = val[8:0];
      CFG_ROI_W: roi_w = val;
      CFG_ROI_H: roi_h = val;
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_region(logic [8:0] x, logic [8:0] y, logic [9:0] w, logic [9:0] h);
    wait_drained();
    write_reg(CFG_ROI_X, {1'b0, x});
    write_reg(CFG_ROI_Y, {1'b0, y});
    write_reg(CFG_ROI_W, w);
    write_reg(CFG_ROI_H, h);
  endtask

  function automatic logic signed [15:0] rand_pixel();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 6) return 16'($urandom_range(1, 32767));
    if (p < 7) return 16'sd0;
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_item(CMD_QUERY, 9'd0, 9'd0, 16'sd0);
    send_item(CMD_LOAD, 9'd0, 9'd0, 16'sd1);
    send_item(CMD_LOAD, 9'd511, 9'd0, 16'sd32767);
    send_item(CMD_LOAD, 9'd0, 9'd511, 16'sh7fff);
    send_item(CMD_LOAD, 9'd511, 9'd511, 16'sd5);
    send_item(CMD_LOAD, 9'd200, 9'd300, 16'sh8000);
    send_item(CMD_LOAD, 9'd201, 9'd300, -16'sd1);
    send_item(CMD_LOAD, 9'd202, 9'd300, 16'shffff);
    send_item(CMD_QUERY, 9'd0, 9'd0, 16'sd0);
    send_item(CMD_QUERY, 9'd511, 9'd511, 16'shaaaa);
    send_item(CMD_QUERY, 9'd511, 9'd0, 16'sh5555);
    send_item(CMD_QUERY, 9'd200, 9'd300, 16'sd0);
    send_item(CMD_SPARE, 9'd0, 9'd0, 16'sd7);
    send_item(CMD_LOAD, 9'd0, 9'd0, 16'sd0);
    send_item(CMD_QUERY, 9'd0, 9'd0, 16'sd0);
    send_item(CMD_LOAD, 9'd0, 9'd0, 16'sd9);
    send_item(CMD_QUERY, 9'd0, 9'd511, 16'sd0);
    send_item(CMD_CLEAR, 9'd0, 9'd0, 16'sd0);
    send_item(CMD_QUERY, 9'd511, 9'd511, 16'sd0);
  endtask

  task automatic test_region_edges();
    set_region(9'd500, 9'd505, 10'd100, 10'd0);
    send_item(CMD_LOAD, 9'd499, 9'd505, 16'sd3);
    send_item(CMD_LOAD, 9'd500, 9'd505, 16'sd3);
    send_item(CMD_LOAD, 9'd511, 9'd511, 16'sd3);
    send_item(CMD_QUERY, 9'd511, 9'd511, 16'sd0);
    send_item(CMD_QUERY, 9'd499, 9'd505, 16'sd0);
    set_region(9'd0, 9'd0, 10'd1, 10'd1);
    send_item(CMD_QUERY, 9'd511, 9'd511, 16'sd0);
    send_item(CMD_LOAD, 9'd0, 9'd0, 16'sd1);
    send_item(CMD_QUERY, 9'd0, 9'd0, 16'sd0);
    set_region(9'd511, 9'd511, 10'd512, 10'd512);
    send_item(CMD_QUERY, 9'd511, 9'd511, 16'sd0);
  endtask

  task automatic run_phase(int n, logic [8:0] c0, logic [8:0] r0, int unsigned sz);
    logic [1:0] cmd;
    int unsigned p;
    logic [8:0] c, r;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 50) cmd = CMD_LOAD;
      else if (p < 97) cmd = CMD_QUERY;
      else if (p < 98) cmd = CMD_SPARE;
      else cmd = CMD_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
        c = 9'($urandom); r = 9'($urandom);
      end else begin
        c = 9'(c0 + $urandom_range(0, sz - 1));
        r = 9'(r0 + $urandom_range(0, sz - 1));
      end
      send_item(cmd, c, r, rand_pixel());
    end
  endtask

  task automatic test_random();
    logic [8:0] x, y;
    for (int ph = 0; ph < 8; ph++) begin
      x = 9'($urandom); y = 9'($urandom);
      case (ph % 4)
        0: set_region(9'd0, 9'd0, 10'd0, 10'd0);
        1: set_region(x, y, 10'($urandom_range(1, 64)), 10'($urandom_range(1, 64)));
        2: set_region(x, y, 10'd512, 10'($urandom));
        default: set_region(9'($urandom_range(0, 40)), 9'($urandom_range(0, 40)),
                            10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)));
      endcase
      send_item(CMD_CLEAR, 9'($urandom), 9'($urandom), 16'($urandom));
      run_phase(160, (ph % 4 == 0) ? 9'($urandom) : x, (ph % 4 == 0) ? 9'($urandom) : y,
                (ph < 4) ? 12 : 40);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_stall_on) out_ch.ready <= (gap_len() == 0);
      else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dist_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no query waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.is_foreground !== e.fg) begin
          $error("is_foreground exp %0d got %0d", e.fg, out_ch.is_foreground); errors++;
        end
        if (out_ch.dist_top !== e.top) begin
          $error("dist_top exp %0d got %0d", e.top, out_ch.dist_top); errors++;
        end
        if (out_ch.dist_bottom !== e.bottom) begin
          $error("dist_bottom exp %0d got %0d", e.bottom, out_ch.dist_bottom); errors++;
        end
        if (out_ch.dist_left !== e.left) begin
          $error("dist_left exp %0d got %0d", e.left, out_ch.dist_left); errors++;
        end
        if (out_ch.dist_right !== e.right) begin
          $error("dist_right exp %0d got %0d", e.right, out_ch.dist_right); errors++;
        end
        if (out_ch.diag_top_left !== e.tl) begin
          $error("diag_top_left exp %0d got %0d", e.tl, out_ch.diag_top_left); errors++;
        end
        if (out_ch.diag_top_right !== e.tr) begin
          $error("diag_top_right exp %0d got %0d", e.tr, out_ch.diag_top_right); errors++;
        end
        if (out_ch.diag_bottom_left !== e.bl) begin
          $error("diag_bottom_left exp %0d got %0d", e.bl, out_ch.diag_bottom_left); errors++;
        end
        if (out_ch.diag_bottom_right !== e.br) begin
          $error("diag_bottom_right exp %0d got %0d", e.br, out_ch.diag_bottom_right);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.cmd = CMD_CLEAR; in_ch.col = '0; in_ch.row = '0;
    in_ch.pixel_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_ROI_X; cfg_ch.data = '0;
    roi_x = 0; roi_y = 0; roi_w = 10'd512; roi_h = 10'd512;
    wipe_slice();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_lo[i] = 0; col_hi[i] = 0; row_lo[i] = 0; row_hi[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_region_edges();
    rx_stall_on = 1'b0;
    set_region(9'd0, 9'd0, 10'd512, 10'd512);
    run_phase(60, 9'd100, 9'd100, 8);
    rx_stall_on = 1'b1;
    test_random();
    wait_drained();
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

### foreground_boundary_distances.f
+incdir+sv
sv/fbd_pkg.sv
sv/fbd_if.sv
sv/fbd_ram.sv
sv/fbd_ctrl.sv
sv/fbd_dp.sv
sv/foreground_boundary_distances.sv
sim/fbd_tb_if.sv
sim/testbench.sv
